// ===== design/plbm_pkg.sv =====
package plbm_pkg;

    localparam int RING_PIXELS_DEF = 15;

    localparam int SAMPLE_W = 8;
    localparam int LEVEL_W  = 7;
    localparam int INDEX_W  = 6;
    localparam int CLASS_W  = 2;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;

    // full scale in percent, and the rounding offset of the lit count
    localparam int PCT_FULL   = 100;
    localparam int ROUND_HALF = 50;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(PCT_FULL);

    localparam logic [CFG_DATA_W-1:0] GREEN_LIMIT_RST = 8'd60;
    localparam logic [CFG_DATA_W-1:0] RED_START_RST   = 8'd85;
    localparam logic [CFG_DATA_W-1:0] DECAY_STEP_RST  = 8'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_LIMIT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RED_START   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_STEP  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_BAR = 4'd3;

    typedef enum logic [CLASS_W-1:0] {
        PIX_OFF   = 2'd0,
        PIX_GREEN = 2'd1,
        PIX_AMBER = 2'd2,
        PIX_RED   = 2'd3
    } pix_class_t;

endpackage

// ===== design/peak_level_bargraph_meter_top.sv =====
// Peak level bargraph meter.
// s_ channel: one transaction per frame tick, tdata[7:0] = level sample in
// percent (clamped to 100; a sample not above the held level lets it decay).
// m_ channel: RING_PIXELS transactions per frame, one per ring pixel in
// index order; tlast marks the last pixel of the frame.
// cfg_ channel: register writes (green limit, red start, decay step,
// reverse), always ready; write only while the meter is idle.
// Path: the first pixel of a frame passes the input register, the pixel
// sequencer registers and then the pixel output register.
// Throughput: one pixel per cycle while m_tready is high; the pixel
// sequencer emitting one result per cycle sets this rate.
// A following sample is held in the input register and its frame starts in
// the cycle after the previous frame's last pixel is issued.
// Reset clears the held level to 0, loads the register defaults and empties
// all stages. When m_tready is low the pixel output register holds and the
// sequencer waits; one sample can still be taken into the input register.
module peak_level_bargraph_meter_top
    import plbm_pkg::*;
#(
    parameter int RING_PIXELS = RING_PIXELS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,    // [7:0] level_sample
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,    // [5:0] pixel_index, [7:6] pixel_class,
                                              // [14:8] held_level, [15] zero
    output logic                  m_tlast,    // frame_end
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // scaled pixel position (pos+1)*100 and the lit bound level*N+50
    localparam int SCL_W = $clog2(RING_PIXELS * PCT_FULL + PCT_FULL + 1);
    // thresholds scaled by N: red_start*N and (green_limit+1)*N
    localparam int THR_W = $clog2(256 * RING_PIXELS + 1);
    localparam logic [SCL_W-1:0] STEP_SCL = SCL_W'(PCT_FULL);
    localparam logic [SCL_W-1:0] FIRST_SCL = SCL_W'(PCT_FULL);
    localparam logic [SCL_W-1:0] LAST_SCL = SCL_W'(RING_PIXELS * PCT_FULL);
    localparam logic [INDEX_W-1:0] LAST_PIX = INDEX_W'(RING_PIXELS - 1);
    localparam logic [THR_W-1:0] RED_THR_RST = THR_W'(int'(RED_START_RST) * RING_PIXELS);
    localparam logic [THR_W-1:0] AMB_THR_RST =
        THR_W'((int'(GREEN_LIMIT_RST) + 1) * RING_PIXELS);

    // configuration
    logic [THR_W-1:0]      red_thr_reg;
    logic [THR_W-1:0]      amb_thr_reg;
    logic [CFG_DATA_W-1:0] decay_reg;
    logic                  reverse_reg;

    // input register
    logic                  in_valid_reg;
    logic [SAMPLE_W-1:0]   in_sample_reg;

    // pixel sequencer
    logic                  busy_reg;
    logic [INDEX_W-1:0]    pix_reg;
    logic [SCL_W-1:0]      scl_reg;
    logic [SCL_W-1:0]      bound_reg;
    logic [LEVEL_W-1:0]    level_reg;

    // output register
    logic                  out_valid_reg;
    logic [INDEX_W-1:0]    out_index_reg;
    pix_class_t            out_class_reg;
    logic [LEVEL_W-1:0]    out_level_reg;
    logic                  out_last_reg;

    logic                  advance;
    logic                  last_pix;
    logic                  frame_load;
    logic [LEVEL_W-1:0]    sample_clamped;
    logic [LEVEL_W-1:0]    level_next;
    logic [SCL_W-1:0]      bound_next;
    pix_class_t            class_next;

    assign cfg_ready = 1'b1;
    assign s_tready  = !in_valid_reg;

    assign advance    = !out_valid_reg || m_tready;
    assign last_pix   = (pix_reg == LAST_PIX);
    assign frame_load = in_valid_reg && (!busy_reg || (advance && last_pix));

    always_comb begin
        if (in_sample_reg > SAMPLE_W'(LEVEL_MAX)) begin
            sample_clamped = LEVEL_MAX;
        end else begin
            sample_clamped = in_sample_reg[LEVEL_W-1:0];
        end
        if (sample_clamped > level_reg) begin
            level_next = sample_clamped;
        end else if (CFG_DATA_W'(level_reg) > decay_reg) begin
            level_next = level_reg - decay_reg[LEVEL_W-1:0];
        end else begin
            level_next = '0;
        end
        bound_next = SCL_W'(level_next) * SCL_W'(RING_PIXELS) + SCL_W'(ROUND_HALF);
    end

    // pos < lit  <=>  (pos+1)*100 <= level*N+50
    // pct >= t   <=>  (pos+1)*100 >= t*N
    always_comb begin
        if (scl_reg > bound_reg) begin
            class_next = PIX_OFF;
        end else if (THR_W'(scl_reg) >= red_thr_reg) begin
            class_next = PIX_RED;
        end else if (THR_W'(scl_reg) >= amb_thr_reg) begin
            class_next = PIX_AMBER;
        end else begin
            class_next = PIX_GREEN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_thr_reg <= RED_THR_RST;
            amb_thr_reg <= AMB_THR_RST;
            decay_reg   <= DECAY_STEP_RST;
            reverse_reg <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_GREEN_LIMIT: amb_thr_reg <= (THR_W'(cfg_data) + THR_W'(1))
                                                * THR_W'(RING_PIXELS);
                CFG_RED_START:   red_thr_reg <= THR_W'(cfg_data) * THR_W'(RING_PIXELS);
                CFG_DECAY_STEP:  decay_reg   <= cfg_data;
                CFG_REVERSE_BAR: reverse_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (frame_load) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_sample_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            level_reg <= '0;
        end else if (frame_load) begin
            busy_reg  <= 1'b1;
            level_reg <= level_next;
        end else if (busy_reg && advance && last_pix) begin
            busy_reg  <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (frame_load) begin
            pix_reg   <= '0;
            scl_reg   <= reverse_reg ? LAST_SCL : FIRST_SCL;
            bound_reg <= bound_next;
        end else if (busy_reg && advance) begin
            pix_reg <= pix_reg + INDEX_W'(1);
            scl_reg <= reverse_reg ? (scl_reg - STEP_SCL) : (scl_reg + STEP_SCL);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= busy_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg && advance) begin
            out_index_reg <= pix_reg;
            out_class_reg <= class_next;
            out_level_reg <= level_reg;
            out_last_reg  <= last_pix;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_level_reg, out_class_reg, out_index_reg};
    assign m_tlast  = out_last_reg;

    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> out_index_reg == LAST_PIX)
        else $error("frame end on a pixel other than the last");

    a_pix_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> pix_reg <= LAST_PIX)
        else $error("pixel counter past the ring");

    a_load_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_load |=> busy_reg && pix_reg == '0)
        else $error("frame load did not start the sequencer");

    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> out_level_reg <= LEVEL_MAX)
        else $error("held level above full scale");

endmodule

// ===== bench/tb_peak_level_bargraph_meter_top.sv =====
module tb_peak_level_bargraph_meter_top;
    import plbm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING = RING_PIXELS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 12;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 54;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 4'd15;

    typedef struct packed {
        logic [INDEX_W-1:0] ring_pos;
        pix_class_t         cls;
        logic [LEVEL_W-1:0] held;
        logic               last;
    } pixel_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [15:0]           m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // meter state as the bench sees it
    int held_pct;
    int green_lim;
    int red_from;
    int decay_pct;
    bit reversed;

    logic [7:0] sample_queue[$];
    pixel_t     frame_pixels[$];
    int         mismatches = 0;
    int         cycles = 0;
    bit         calm = 1'b0;

    peak_level_bargraph_meter_top #(
        .RING_PIXELS(RING)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic void predict_frame(input logic [7:0] raw);
        int smp;
        int lit;
        int pos;
        int pct;
        pixel_t px;
        smp = (raw > PCT_FULL) ? PCT_FULL : int'(raw);
        if (smp > held_pct) begin
            held_pct = smp;
        end else begin
            held_pct = (held_pct > decay_pct) ? held_pct - decay_pct : 0;
        end
        lit = (held_pct * RING + ROUND_HALF) / PCT_FULL;
        for (int p = 0; p < RING; p++) begin
            pos = reversed ? RING - 1 - p : p;
            px.ring_pos = INDEX_W'(p);
            px.held = LEVEL_W'(held_pct);
            px.last = (p == RING - 1);
            if (pos < lit) begin
                pct = ((pos + 1) * PCT_FULL) / RING;
                if (pct >= red_from) begin
                    px.cls = PIX_RED;
                end else if (pct > green_lim) begin
                    px.cls = PIX_AMBER;
                end else begin
                    px.cls = PIX_GREEN;
                end
            end else begin
                px.cls = PIX_OFF;
            end
            frame_pixels.push_back(px);
        end
    endfunction

    function automatic void check_pixel(input logic [15:0] data, input logic last);
        pixel_t want;
        pixel_t got;
        got.ring_pos = data[5:0];
        got.cls = pix_class_t'(data[7:6]);
        got.held = data[14:8];
        got.last = last;
        if (frame_pixels.size() == 0) begin
            if (mismatches < 10) begin
                $display("unexpected pixel: index %0d class %0d level %0d end %0b",
                         got.ring_pos, got.cls, got.held, got.last);
            end
            mismatches++;
        end else begin
            want = frame_pixels.pop_front();
            if (got !== want) begin
                if (mismatches < 10) begin
                    $display("pixel mismatch: exp index %0d class %0d level %0d end %0b, got index %0d class %0d level %0d end %0b",
                             want.ring_pos, want.cls, want.held, want.last,
                             got.ring_pos, got.cls, got.held, got.last);
                end
                mismatches++;
            end
        end
    endfunction

    // sample driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_frame(s_tdata);
            end
            if (!s_tvalid || s_tready) begin
                if (sample_queue.size() > 0 && (calm || $urandom_range(0, 99) >= 30)) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= sample_queue.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // pixel monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            check_pixel(m_tdata, m_tlast);
        end
        m_tready <= calm || ($urandom_range(0, 99) >= 30);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("peak_level_bargraph_meter_top regression: fail");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_GREEN_LIMIT: green_lim = int'(val);
            CFG_RED_START:   red_from = int'(val);
            CFG_DECAY_STEP:  decay_pct = int'(val);
            CFG_REVERSE_BAR: reversed = val[0];
            default: ;
        endcase
    endtask

    task automatic set_meter(input logic [7:0] g, input logic [7:0] r,
                             input logic [7:0] d, input logic [7:0] rev);
        write_reg(CFG_GREEN_LIMIT, g);
        write_reg(CFG_RED_START, r);
        write_reg(CFG_DECAY_STEP, d);
        write_reg(CFG_REVERSE_BAR, rev);
    endtask

    // sender holds off until the meter has emitted everything
    task automatic wait_idle();
        while (sample_queue.size() > 0 || s_tvalid || frame_pixels.size() > 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [7:0] draw_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            return 8'd0;
        end else if (r < 75) begin
            return 8'($urandom_range(1, 100));
        end else if (r < 85) begin
            return 8'($urandom_range(101, 255));
        end
        // small values mostly land below the held level and only let it decay
        return 8'($urandom_range(1, 20));
    endfunction

    initial begin
        logic [7:0] directed[] = '{8'd0, 8'd1, 8'd4, 8'd3, 8'd100, 8'd255, 8'd101,
                                   8'd50, 8'd0, 8'd0, 8'd0, 8'd128, 8'd200, 8'd99,
                                   8'd0, 8'd1, 8'd127, 8'd64, 8'd33, 8'd0};
        held_pct = 0;
        green_lim = int'(GREEN_LIMIT_RST);
        red_from = int'(RED_START_RST);
        decay_pct = int'(DECAY_STEP_RST);
        reversed = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // register defaults straight after reset
        foreach (directed[i]) sample_queue.push_back(directed[i]);

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_idle();
            calm = (ph == 3);
            case (ph)
                0: set_meter(8'd0, 8'd0, 8'd0, 8'd0);
                1: set_meter(8'd255, 8'd255, 8'd255, 8'd1);
                2: begin
                    // red wins over green where the ranges overlap
                    set_meter(8'd90, 8'd40, 8'd1, 8'd1);
                    write_reg(CFG_UNUSED_LO, 8'hAA);
                    write_reg(CFG_UNUSED_HI, 8'h55);
                    write_reg(CFG_REVERSE_BAR, 8'hFF);
                end
                4: set_meter(GREEN_LIMIT_RST, RED_START_RST, DECAY_STEP_RST, 8'hFE);
                default: set_meter(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                   8'($urandom_range(0, 30)), 8'($urandom_range(0, 255)));
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // bias toward a peak followed by a decay tail
                if (i % 9 == 0) begin
                    sample_queue.push_back(8'($urandom_range(60, 255)));
                end else begin
                    sample_queue.push_back(draw_sample());
                end
            end
        end

        wait_idle();
        if (mismatches == 0 && frame_pixels.size() == 0) begin
            $display("peak_level_bargraph_meter_top regression: pass");
        end else begin
            $display("peak_level_bargraph_meter_top regression: fail");
        end
        $finish;
    end

endmodule
